// File: hdl/iarf_pkg.sv
// Shared types, codes, constants and character helpers for the radix formatter.
package iarf_pkg;

  localparam int NUM_BITS_DEF = 32;
  localparam int PTR_BITS_DEF = 64;

  localparam logic [7:0] CHR_ZERO       = 8'd48;  // '0'
  localparam logic [7:0] CHR_LOWER_OFS  = 8'd87;  // 'a' - 10
  localparam logic [7:0] CHR_UPPER_OFS  = 8'd55;  // 'A' - 10
  localparam logic [7:0] CHR_X          = 8'h78;  // 'x'
  localparam logic [4:0] NIL_LEN        = 5'd5;

  typedef enum logic [2:0] {
    ACT_DEC  = 3'd0,
    ACT_OCT  = 3'd1,
    ACT_HEXL = 3'd2,
    ACT_HEXU = 3'd3,
    ACT_PTR  = 3'd4
  } act_e_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_PRE,
    ST_NIL,
    ST_DIG
  } state_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic [4:0] char_total;
  } out_item_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    if (d < 4'd10) begin
      base = CHR_ZERO;
    end else if (upper) begin
      base = CHR_UPPER_OFS;
    end else begin
      base = CHR_LOWER_OFS;
    end
    return base + {4'b0000, d};
  endfunction

  // "(nil)" one character at a time
  function automatic logic [7:0] nil_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h28;  // '('
      3'd1:    c = 8'h6e;  // 'n'
      3'd2:    c = 8'h69;  // 'i'
      3'd3:    c = 8'h6c;  // 'l'
      default: c = 8'h29;  // ')'
    endcase
    return c;
  endfunction

endpackage

// File: hdl/iarf_dabble.sv
// One shift-and-add-3 step of binary to BCD conversion over a row of digits.
module iarf_dabble #(
  parameter int DIGITS = 10
) (
  input  logic [DIGITS*4-1:0] bcd_i,
  input  logic                bit_i,
  output logic [DIGITS*4-1:0] bcd_o
);

  logic [DIGITS*4-1:0] adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_i[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_i[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_i[i*4 +: 4];
      end
    end
  end

  assign bcd_o = {adj[DIGITS*4-2:0], bit_i};

endmodule

// File: hdl/integer_to_ascii_radix_formatter.sv
// Top level: printf-style integer to ASCII formatter (%u %o %x %X %p).
// Sequence: decimal first runs the serial double-dabble conversion over all NUM_BITS bits,
//   then drops leading zeros, then sends one character per cycle while the output is free.
// Octal and hex skip the conversion. Pointer sends the "0x" prefix first; a null pointer
//   gives "(nil)". Flow: one item at a time; in_ready is high only in idle, between
//   items, so no new item is taken until the previous one has emitted its last character.
// Reset: synchronous active-low rst_n returns the sequencer to idle and empties the output.
module integer_to_ascii_radix_formatter #(
  parameter int NUM_BITS = iarf_pkg::NUM_BITS_DEF,
  parameter int PTR_BITS = iarf_pkg::PTR_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  iarf_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output iarf_pkg::out_item_t out_data
);

  import iarf_pkg::*;

  // Digit counts of the widest text in each radix
  localparam int DEC_N  = (NUM_BITS * 30103) / 100000 + 1;
  localparam int OCT_N  = (NUM_BITS + 2) / 3;
  localparam int HEXN_N = (NUM_BITS + 3) / 4;
  localparam int HEXP_N = (PTR_BITS + 3) / 4;
  localparam int MAX_A  = (DEC_N > OCT_N) ? DEC_N : OCT_N;
  localparam int MAXD   = (MAX_A > HEXP_N) ? MAX_A : HEXP_N;
  localparam int DIG_W  = MAXD * 4;
  localparam int DEC_W  = DEC_N * 4;
  localparam int OCT_W  = OCT_N * 3;
  localparam int HEXN_W = HEXN_N * 4;
  localparam int HEXP_W = HEXP_N * 4;
  localparam int NDW    = $clog2(MAXD + 1);
  localparam int BCW    = $clog2(NUM_BITS + 1);

  // Sequencer state
  state_t             state_r, state_nxt;
  act_e_t             mode_r, mode_nxt;
  logic [DIG_W-1:0]   dig_r, dig_nxt;     // digits, most significant at the top
  logic [NDW-1:0]     ndig_r, ndig_nxt;   // digits still to go
  logic [4:0]         cnt_r, cnt_nxt;     // characters sent so far
  logic [2:0]         idx_r, idx_nxt;     // position in prefix or "(nil)"
  logic [NUM_BITS-1:0] bin_r, bin_nxt;    // binary still to feed the BCD loop
  logic [BCW-1:0]     bitcnt_r, bitcnt_nxt;

  // Output register
  logic      out_valid_r;
  out_item_t out_r;

  logic      emit;
  out_item_t emit_item;
  logic      out_free;

  logic [DEC_W-1:0]  dab_out;
  logic [OCT_W-1:0]  oct_src;
  logic [DIG_W-1:0]  oct_exp;
  logic [HEXN_W-1:0] hexn_src;
  logic [HEXP_W-1:0] hexp_src;
  logic [3:0]        dig_top;
  logic              ptr_zero;
  logic              last_dig;

  // Shared BCD step works on the top DEC_N digits, so the result comes out left aligned
  iarf_dabble #(
    .DIGITS(DEC_N)
  ) u_dabble (
    .bcd_i(dig_r[DIG_W-1 -: DEC_W]),
    .bit_i(bin_r[NUM_BITS-1]),
    .bcd_o(dab_out)
  );

  assign oct_src  = OCT_W'(in_data.value[NUM_BITS-1:0]);
  assign hexn_src = HEXN_W'(in_data.value[NUM_BITS-1:0]);
  assign hexp_src = HEXP_W'(in_data.value[PTR_BITS-1:0]);
  assign ptr_zero = (in_data.value[PTR_BITS-1:0] == '0);
  assign dig_top  = dig_r[DIG_W-1 -: 4];
  assign last_dig = (ndig_r == NDW'(1));
  assign out_free = !out_valid_r || out_ready;

  // Octal digits widened to nibbles, left aligned
  always_comb begin
    oct_exp = '0;
    for (int i = 0; i < OCT_N; i++) begin
      oct_exp[(MAXD - OCT_N + i)*4 +: 4] = {1'b0, oct_src[i*3 +: 3]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    dig_r    <= dig_nxt;
    ndig_r   <= ndig_nxt;
    cnt_r    <= cnt_nxt;
    idx_r    <= idx_nxt;
    bin_r    <= bin_nxt;
    bitcnt_r <= bitcnt_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    dig_nxt    = dig_r;
    ndig_nxt   = ndig_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    bin_nxt    = bin_r;
    bitcnt_nxt = bitcnt_r;
    in_ready   = 1'b0;
    emit       = 1'b0;
    emit_item  = '0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cnt_nxt  = '0;
          idx_nxt  = '0;
          mode_nxt = act_e_t'(in_data.action);
          case (act_e_t'(in_data.action))
            ACT_DEC: begin
              dig_nxt    = '0;
              bin_nxt    = in_data.value[NUM_BITS-1:0];
              bitcnt_nxt = BCW'(NUM_BITS);
              ndig_nxt   = NDW'(DEC_N);
              state_nxt  = ST_CONV;
            end
            ACT_OCT: begin
              dig_nxt   = oct_exp;
              ndig_nxt  = NDW'(OCT_N);
              state_nxt = ST_SKIP;
            end
            ACT_HEXL, ACT_HEXU: begin
              dig_nxt   = DIG_W'(hexn_src) << ((MAXD - HEXN_N) * 4);
              ndig_nxt  = NDW'(HEXN_N);
              state_nxt = ST_SKIP;
            end
            ACT_PTR: begin
              dig_nxt   = DIG_W'(hexp_src) << ((MAXD - HEXP_N) * 4);
              ndig_nxt  = NDW'(HEXP_N);
              state_nxt = ptr_zero ? ST_NIL : ST_SKIP;
            end
            default: begin
              // undefined selector: item is dropped without output
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_CONV: begin
        dig_nxt    = DIG_W'(dab_out) << (DIG_W - DEC_W);
        bin_nxt    = bin_r << 1;
        bitcnt_nxt = bitcnt_r - BCW'(1);
        if (bitcnt_r == BCW'(1)) begin
          state_nxt = ST_SKIP;
        end
      end

      ST_SKIP: begin
        // drop leading zeros, always keep one digit
        if (!last_dig && dig_top == 4'd0) begin
          dig_nxt  = dig_r << 4;
          ndig_nxt = ndig_r - NDW'(1);
        end else begin
          state_nxt = (mode_r == ACT_PTR) ? ST_PRE : ST_DIG;
        end
      end

      ST_PRE: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_item.char_code = (idx_r == 3'd0) ? CHR_ZERO : CHR_X;
          cnt_nxt             = cnt_r + 5'd1;
          idx_nxt             = idx_r + 3'd1;
          if (idx_r != 3'd0) begin
            state_nxt = ST_DIG;
          end
        end
      end

      ST_NIL: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_item.char_code = nil_char(idx_r);
          idx_nxt             = idx_r + 3'd1;
          if (idx_r == 3'd4) begin
            emit_item.last_char  = 1'b1;
            emit_item.char_total = NIL_LEN;
            state_nxt            = ST_IDLE;
          end
        end
      end

      ST_DIG: begin
        if (out_free) begin
          emit                = 1'b1;
          emit_item.char_code = digit_char(dig_top, mode_r == ACT_HEXU);
          dig_nxt             = dig_r << 4;
          ndig_nxt            = ndig_r - NDW'(1);
          cnt_nxt             = cnt_r + 5'd1;
          if (last_dig) begin
            emit_item.last_char  = 1'b1;
            emit_item.char_total = cnt_r + 5'd1;
            state_nxt            = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: holds one character until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_last_has_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_char |-> out_data.char_total != 5'd0)
    else $error("last character without a count");

  a_mid_no_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_char |-> out_data.char_total == 5'd0)
    else $error("count on a non-final character");

  a_dig_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIG |-> ndig_r != '0)
    else $error("digit emission with no digits left");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action <= ACT_PTR |=> !in_ready)
    else $error("accepted item did not start work");
`endif

endmodule

// File: bench/tb_top.sv
// Self-checking bench for the integer to ASCII radix formatter: directed and random items.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iarf_pkg::*;

  // Run shape
  localparam int RAND_ITEMS    = 160;   // random items with a defined selector
  localparam int TAIL_ITEMS    = 25;    // last items go out with no idling on either side
  localparam int HOLD_AT_ITEM  = 40;    // receiver hold-off starts after this many inputs
  localparam int HOLD_CYCLES   = 400;   // length of that hold-off
  localparam int DRAIN_CYCLES  = 60;    // quiet time after the last expected character
  localparam int STALL_LIMIT   = 3000;  // cycles with no handshake before giving up

  // Selector codes the block must ignore
  localparam logic [2:0] ACT_UNDEF_LO = 3'd5;
  localparam logic [2:0] ACT_UNDEF_HI = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  integer_to_ascii_radix_formatter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Items waiting to be offered, and characters waiting to come out
  in_item_t  pending_items[$];
  out_item_t expected_chars[$];

  int  items_taken = 0;   // inputs accepted (written by the driver only)
  int  n_ignored = 0;     // accepted inputs with an undefined selector
  int  chars_seen = 0;
  int  n_errors = 0;
  logic tail_phase = 1'b0;
  int  quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Predictor: renders one item as printf would and queues its characters.
  // Returns the number of characters queued (zero for an undefined selector).
  // ---------------------------------------------------------------------------
  function automatic int format_item(input in_item_t it);
    logic [7:0]  text[$];
    logic [63:0] v;
    logic [63:0] num_mask;
    logic [63:0] ptr_mask;
    int          radix;
    int          d;
    int          len;
    logic        upper;
    logic        is_ptr;
    string       nil_text;
    out_item_t   o;

    num_mask = (NUM_BITS_DEF >= 64) ? '1 : ((64'd1 << NUM_BITS_DEF) - 64'd1);
    ptr_mask = (PTR_BITS_DEF >= 64) ? '1 : ((64'd1 << PTR_BITS_DEF) - 64'd1);
    nil_text = "(nil)";
    upper    = 1'b0;
    is_ptr   = 1'b0;
    radix    = 16;
    v        = it.value & num_mask;

    case (it.action)
      ACT_DEC:  radix = 10;
      ACT_OCT:  radix = 8;
      ACT_HEXL: radix = 16;
      ACT_HEXU: begin
        radix = 16;
        upper = 1'b1;
      end
      ACT_PTR: begin
        is_ptr = 1'b1;
        v      = it.value & ptr_mask;
      end
      default: return 0;
    endcase

    if (is_ptr && v == 64'd0) begin
      // null pointer prints as a word, not a number
      for (int i = 0; i < nil_text.len(); i++) text.push_back(nil_text[i]);
    end else begin
      // digits come out least significant first, so build the text from the front
      do begin
        d = int'(v % radix);
        if (d >= 10) text.push_front((upper ? CHR_UPPER_OFS : CHR_LOWER_OFS) + 8'(d));
        else         text.push_front(CHR_ZERO + 8'(d));
        v = v / radix;
      end while (v != 64'd0);
      if (is_ptr) begin
        text.push_front(CHR_X);
        text.push_front(CHR_ZERO);
      end
    end

    len = text.size();
    for (int k = 0; k < len; k++) begin
      o.char_code  = text[k];
      o.last_char  = (k == len - 1);
      o.char_total = (k == len - 1) ? 5'(len) : 5'd0;
      expected_chars.push_back(o);
    end
    return len;
  endfunction

  task automatic add_item(input logic [2:0] act, input logic [63:0] val);
    in_item_t it;
    it.action = act;
    it.value  = val;
    pending_items.push_back(it);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued items, with random idle bursts. Once valid is up it
  // holds with the same payload until in_ready takes the item.
  // ---------------------------------------------------------------------------
  int   drv_gap = 0;
  logic drv_idle_on = 1'b1;

  always @(posedge clk) begin : drive_items
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (format_item(in_data) == 0) n_ignored++;
        items_taken <= items_taken + 1;
      end
      // an offered item that has not been taken stays put
      next_valid = in_valid && !in_ready;
      if (!next_valid) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (pending_items.size() != 0) begin
          if (drv_idle_on && !tail_phase && $urandom_range(0, 5) == 0) begin
            // start an idle burst: this cycle idles and drv_gap holds the rest
            drv_gap = $urandom_range(0, 11);
          end else begin
            in_data    <= pending_items.pop_front();
            next_valid = 1'b1;
            // alternate between idling and back-to-back stretches
            if ($urandom_range(0, 29) == 0) drv_idle_on = ~drv_idle_on;
          end
        end
      end
      in_valid   <= next_valid;
      tail_phase <= (pending_items.size() < TAIL_ITEMS);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted character against the oldest expectation and
  // drives out_ready, with random stall bursts and one long hold-off that lets
  // the block back up into its input.
  // ---------------------------------------------------------------------------
  int   rcv_gap = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic rcv_idle_on = 1'b1;

  always @(posedge clk) begin : check_chars
    out_item_t want;
    logic      next_ready;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          $error("unexpected character 0x%02h with no item pending", out_data.char_code);
          n_errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.char_code !== want.char_code) begin
            $error("char_code: expected 0x%02h, got 0x%02h", want.char_code, out_data.char_code);
            n_errors++;
          end
          if (out_data.last_char !== want.last_char) begin
            $error("last_char: expected %0d, got %0d", want.last_char, out_data.last_char);
            n_errors++;
          end
          if (out_data.char_total !== want.char_total) begin
            $error("char_total: expected %0d, got %0d", want.char_total, out_data.char_total);
            n_errors++;
          end
        end
      end

      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!hold_done && items_taken >= HOLD_AT_ITEM) begin
        // long back-pressure while the driver keeps offering
        hold_done  = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        next_ready = 1'b0;
      end else if (rcv_gap > 0) begin
        rcv_gap--;
        next_ready = 1'b0;
      end else if (rcv_idle_on && !tail_phase && $urandom_range(0, 5) == 0) begin
        rcv_gap    = $urandom_range(0, 11);
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
        if ($urandom_range(0, 99) == 0) rcv_idle_on = ~rcv_idle_on;
      end
      out_ready <= next_ready;
    end
  end

  // Watchdog: too long without any handshake means the block is stuck
  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d characters outstanding",
                 quiet_cycles, expected_chars.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [2:0]  act;
    logic [63:0] val;
    int          n_listed;

    // zero in every mode, "(nil)" for the null pointer
    add_item(ACT_DEC,  64'd0);
    add_item(ACT_OCT,  64'd0);
    add_item(ACT_HEXL, 64'd0);
    add_item(ACT_HEXU, 64'd0);
    add_item(ACT_PTR,  64'd0);
    // widest numeric values; octal needs all eleven digits
    add_item(ACT_DEC,  64'h0000_0000_FFFF_FFFF);
    add_item(ACT_OCT,  64'h0000_0000_FFFF_FFFF);
    add_item(ACT_OCT,  64'h0000_0000_4000_0000);
    add_item(ACT_HEXL, 64'h0000_0000_FFFF_FFFF);
    add_item(ACT_HEXU, 64'h0000_0000_FFFF_FFFF);
    // upper word is dropped in numeric modes
    add_item(ACT_DEC,  64'hFFFF_FFFF_0000_0000);
    add_item(ACT_HEXU, 64'hDEAD_BEEF_0000_ABCD);
    add_item(ACT_HEXL, 64'h0000_0000_ABCD_EF01);
    add_item(ACT_HEXU, 64'h0000_0000_ABCD_EF01);
    // decimal digit rollovers
    add_item(ACT_DEC,  64'd9);
    add_item(ACT_DEC,  64'd10);
    add_item(ACT_DEC,  64'd1000000000);
    add_item(ACT_OCT,  64'd8);
    // pointer: full width, smallest, top bit, low word zero but not null
    add_item(ACT_PTR,  64'hFFFF_FFFF_FFFF_FFFF);
    add_item(ACT_PTR,  64'd1);
    add_item(ACT_PTR,  64'h8000_0000_0000_0000);
    add_item(ACT_PTR,  64'h0000_0001_0000_0000);
    // undefined selectors produce nothing
    for (int a = ACT_UNDEF_LO; a <= ACT_UNDEF_HI; a++) add_item(3'(a), 64'h0123_4567_89AB_CDEF);

    n_listed = 0;
    while (n_listed < RAND_ITEMS) begin
      if ($urandom_range(0, 12) == 0) begin
        act = 3'($urandom_range(ACT_UNDEF_LO, ACT_UNDEF_HI));
      end else begin
        act = 3'($urandom_range(ACT_DEC, ACT_PTR));
        n_listed++;
      end
      case ($urandom_range(0, 5))
        0:       val = 64'($urandom_range(0, 20));
        1:       val = 64'd1 << $urandom_range(0, 63);
        2:       val = {$urandom, $urandom} >> $urandom_range(0, 63);
        3:       val = ~64'd0 >> $urandom_range(0, 63);
        default: val = {$urandom, $urandom};
      endcase
      add_item(act, val);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // everything offered, taken, and printed
    while (pending_items.size() != 0 || in_valid || expected_chars.size() != 0)
      @(posedge clk);
    // an ignored item or a stray character may still be on its way
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d items (%0d with undefined selector) through all five conversions,",
             items_taken, n_ignored);
    $display("checked %0d characters with random stalls and one long hold-off; %0d errors",
             chars_seen, n_errors);
    if (n_errors == 0 && expected_chars.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/iarf_pkg.sv
hdl/iarf_dabble.sv
hdl/integer_to_ascii_radix_formatter.sv
bench/tb_top.sv
